### src/dmdu_pkg.sv
// Shared types, constants and codes of the dot matrix difference update unit.
`timescale 1ns / 1ps

package dmdu_pkg;

   // Default store geometry
   localparam int DEF_MAX_DISPLAY_WIDTH  = 128;
   localparam int DEF_MAX_DISPLAY_HEIGHT = 32;

   // One input byte carries eight pixels, one lane each
   localparam int NUM_LANES = 8;
   localparam int DIV_STEPS = 7;   // quotient bits of a 7-bit x
   localparam int STEP_W    = 3;

   // Field widths
   localparam int PW_W   = 8;
   localparam int PH_W   = 5;
   localparam int PC_W   = 4;
   localparam int BCOL_W = 4;
   localparam int ROW_W  = 5;
   localparam int PIX_W  = 8;
   localparam int X_W    = 7;
   localparam int PANEL_W = 4;
   localparam int DX_W   = 7;
   localparam int DY_W   = 4;
   localparam int DISPW_W = PW_W + PC_W;
   localparam int DISPH_W = PH_W + 1;

   localparam int REQ_DATA_W = 24;  // 17 bits of fields, padded to bytes
   localparam int RSP_DATA_W = 16;
   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 8;

   // Register reset values
   localparam logic [PW_W-1:0] RST_PANEL_WIDTH  = 8'd28;
   localparam logic [PH_W-1:0] RST_PANEL_HEIGHT = 5'd16;
   localparam logic [PC_W-1:0] RST_PANEL_COUNT  = 4'd1;
   localparam logic            RST_STACKED      = 1'b0;

   typedef enum logic [CSR_ADDR_W-1:0] {
      REG_PANEL_WIDTH  = 2'd0,
      REG_PANEL_HEIGHT = 2'd1,
      REG_PANEL_COUNT  = 2'd2,
      REG_STACKED_MODE = 2'd3
   } reg_index_type;

   typedef enum logic {
      OP_UPDATE = 1'b0,
      OP_CLEAR  = 1'b1
   } op_type;

   // One flip command
   typedef struct packed {
      logic               dot_state;
      logic [DY_W-1:0]    dot_y;
      logic [DX_W-1:0]    dot_x;
      logic [PANEL_W-1:0] panel_index;
   } cmd_type;

   // Per-item context shared by all lanes
   typedef struct packed {
      op_type              op;
      logic [BCOL_W-1:0]   byte_column;
      logic [PW_W-1:0]     panel_width;
      logic                stacked;
      logic                top_half;
      logic                row_ok;
      logic [DY_W-1:0]     dot_y;
      logic [DISPW_W-1:0]  disp_w;
   } ctx_type;

   // What one lane reports once its division is done
   typedef struct packed {
      cmd_type cmd;
      logic    emit;
      logic    store_bit;
   } lane_out_type;

endpackage

### src/dmdu_lane.sv
// One pixel lane: bit-serial x / panel_width, panel mapping and change detect.
`timescale 1ns / 1ps

module dmdu_lane #(
   parameter int LANE = 0
) (
   input  logic                          clock,
   input  logic                          start,
   input  logic                          step,
   input  logic [dmdu_pkg::STEP_W-1:0]   bit_sel,
   input  dmdu_pkg::ctx_type             ctx,
   input  logic                          old_bit,
   input  logic                          new_bit,
   output dmdu_pkg::lane_out_type        result
);
   import dmdu_pkg::*;

   logic [X_W-1:0]  x;
   logic [PW_W-1:0] rem_ff, rem_in;
   logic [X_W-1:0]  quo_ff, quo_in;
   logic [PW_W:0]   shifted;
   logic            ge;
   logic [PW_W-1:0] mirror_x;
   logic            in_disp;

   assign x = {ctx.byte_column, 3'(LANE)};

   // restoring division, one quotient bit per step, MSB first
   always_comb begin
      shifted = {rem_ff, x[bit_sel]};
      ge      = shifted >= {1'b0, ctx.panel_width};
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      if (start) begin
         rem_in = '0;
         quo_in = '0;
      end else if (step) begin
         rem_in = ge ? PW_W'(shifted - {1'b0, ctx.panel_width}) : PW_W'(shifted);
         quo_in = {quo_ff[X_W-2:0], ge};
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign mirror_x = ctx.panel_width - rem_ff - 8'd1;
   assign in_disp  = ctx.row_ok && ({{(DISPW_W-X_W){1'b0}}, x} < ctx.disp_w);

   always_comb begin
      result.cmd.dot_y     = ctx.dot_y;
      result.cmd.dot_state = (ctx.op == OP_UPDATE) ? new_bit : 1'b0;
      if (ctx.stacked) begin
         result.cmd.panel_index = {quo_ff[PANEL_W-2:0], ctx.top_half};
         result.cmd.dot_x       = ctx.top_half ? mirror_x[DX_W-1:0] : rem_ff[DX_W-1:0];
      end else begin
         result.cmd.panel_index = quo_ff[PANEL_W-1:0];
         result.cmd.dot_x       = rem_ff[DX_W-1:0];
      end
      result.emit      = in_disp && ((ctx.op == OP_CLEAR) || (old_bit != new_bit));
      result.store_bit = in_disp && (ctx.op == OP_UPDATE) && new_bit;
   end

endmodule

### src/dmdu_merge.sv
// Merge stage: serializes lane commands left to right into the output register.
`timescale 1ns / 1ps

module dmdu_merge (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     load,
   input  logic [dmdu_pkg::NUM_LANES-1:0]           load_mask,
   input  dmdu_pkg::cmd_type [dmdu_pkg::NUM_LANES-1:0] lane_cmd,
   output logic                                     busy,
   output logic                                     rsp_tvalid,
   input  logic                                     rsp_tready,
   output logic [dmdu_pkg::RSP_DATA_W-1:0]          rsp_tdata,
   output logic                                     rsp_tlast
);
   import dmdu_pkg::*;

   logic [NUM_LANES-1:0] pending_ff, pending_in;
   logic [NUM_LANES-1:0] pick;
   logic [NUM_LANES-1:0] remaining;
   logic                 out_valid_ff, out_valid_in;
   cmd_type              out_cmd_ff, out_cmd_in;
   logic                 out_last_ff, out_last_in;
   logic                 can_load;
   cmd_type              sel_cmd;

   // lowest lane first: leftmost pixel
   always_comb begin
      pick    = '0;
      sel_cmd = lane_cmd[0];
      for (int i = NUM_LANES - 1; i >= 0; i--) begin
         if (pending_ff[i]) begin
            pick    = NUM_LANES'(1) << i;
            sel_cmd = lane_cmd[i];
         end
      end
   end

   assign remaining = pending_ff & ~pick;
   assign can_load  = (pending_ff != '0) && (!out_valid_ff || rsp_tready);

   always_comb begin
      pending_in   = pending_ff;
      out_valid_in = out_valid_ff;
      out_cmd_in   = out_cmd_ff;
      out_last_in  = out_last_ff;
      if (can_load) begin
         pending_in   = remaining;
         out_valid_in = 1'b1;
         out_cmd_in   = sel_cmd;
         out_last_in  = (remaining == '0);
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
      if (load) begin
         pending_in = load_mask;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff   <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         pending_ff   <= pending_in;
         out_valid_ff <= out_valid_in;
      end
      out_cmd_ff  <= out_cmd_in;
      out_last_ff <= out_last_in;
   end

   assign busy       = (pending_ff != '0);
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_cmd_ff;
   assign rsp_tlast  = out_last_ff;

`ifndef ASSERT_OFF
   a_load_when_empty: assert property (@(posedge clock) disable iff (reset)
      load |-> (pending_ff == '0))
      else $error("merge loaded while commands pending");

   a_one_per_beat: assert property (@(posedge clock) disable iff (reset)
      (can_load && !load) |=> ($countones(pending_ff) == $countones($past(pending_ff)) - 1))
      else $error("merge dropped or kept more than one command");

   a_not_last_has_more: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !out_last_ff) |-> (pending_ff != '0))
      else $error("non-final command with nothing left");
`endif

endmodule

### src/dot_matrix_diff_update_unit.sv
// Top level of the dot matrix difference update unit: store, sequencer, lanes, merge.
`timescale 1ns / 1ps
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+-----------------------------------------------
//  req     | in  | req_tvalid/tready  | tdata: byte_column, row, pixels; tuser: operation
//  rsp     | out | rsp_tvalid/tready  | tdata: panel_index, dot_x, dot_y, dot_state; tlast
//  csr     | in  | csr_we             | csr_addr selects register, csr_wdata value
//
//  A byte is accepted, divided in the lanes one quotient bit per divider step, written
//  back and, when it causes n flip commands, 1 to 8, handed to the merge, which
//  sends one command per beat and is then seen empty; serial x / panel_width and
//  the one-command-per-beat merge set the pace. After reset a clearing pass zeroes
//  all (MAX_DISPLAY_WIDTH+7)/8 * MAX_DISPLAY_HEIGHT store bytes (512 by default),
//  with req_tready low. A stalled rsp holds the merge stage; the next byte is
//  taken while the final command of the previous one still waits.

module dot_matrix_diff_update_unit #(
   parameter int MAX_DISPLAY_WIDTH  = dmdu_pkg::DEF_MAX_DISPLAY_WIDTH,
   parameter int MAX_DISPLAY_HEIGHT = dmdu_pkg::DEF_MAX_DISPLAY_HEIGHT
) (
   input  logic                              clock,
   input  logic                              reset,
   // byte_column [3:0], row [8:4], pixels [16:9], zero [23:17]
   input  logic [dmdu_pkg::REQ_DATA_W-1:0]   req_tdata,
   // operation [0]
   input  logic                              req_tuser,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // panel_index [3:0], dot_x [10:4], dot_y [14:11], dot_state [15]
   output logic [dmdu_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   output logic                              rsp_tlast,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   input  logic                              csr_we,
   input  logic [dmdu_pkg::CSR_ADDR_W-1:0]   csr_addr,
   input  logic [dmdu_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import dmdu_pkg::*;

   localparam int ROW_BYTES = (MAX_DISPLAY_WIDTH + 7) / 8;
   localparam int DEPTH     = ROW_BYTES * MAX_DISPLAY_HEIGHT;
   localparam int ADDR_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam logic [ADDR_W-1:0]  LAST_ADDR = ADDR_W'(DEPTH - 1);
   localparam logic [STEP_W-1:0]  LAST_STEP = STEP_W'(DIV_STEPS - 1);

   typedef enum logic [4:0] {
      ST_CLEAR = 5'b00001,   // zeroing the frame store
      ST_IDLE  = 5'b00010,
      ST_DIV   = 5'b00100,   // lanes divide, store read
      ST_FIN   = 5'b01000,   // write back, hand commands to merge
      ST_EMIT  = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   // configuration registers
   logic [PW_W-1:0] pw_ff;
   logic [PH_W-1:0] ph_ff;
   logic [PC_W-1:0] pc_ff;
   logic            stacked_ff;

   // held item
   op_type            op_ff;
   logic [BCOL_W-1:0] bcol_ff;
   logic [ROW_W-1:0]  row_ff;
   logic [PIX_W-1:0]  pix_ff;

   logic [STEP_W-1:0] step_ff, step_in;
   logic [ADDR_W-1:0] clr_ff, clr_in;

   logic [PIX_W-1:0]  mem [DEPTH];
   logic [PIX_W-1:0]  rd_ff;
   logic [ADDR_W-1:0] mem_addr;
   logic              mem_we, mem_re;
   logic [PIX_W-1:0]  mem_wdata;

   logic              accept;
   logic              addr_ok;
   logic [ADDR_W-1:0] item_addr;
   logic [DISPH_W-1:0] disp_h;
   logic [PH_W-1:0]   ly_top, ly_bot;
   ctx_type           ctx;

   lane_out_type                  lane_res [NUM_LANES];
   cmd_type [NUM_LANES-1:0]       lane_cmd;
   logic [NUM_LANES-1:0]          emit_mask;
   logic [PIX_W-1:0]              store_byte;
   logic                          mrg_busy;
   logic                          mrg_load;

   // ---------------- configuration ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         pw_ff      <= RST_PANEL_WIDTH;
         ph_ff      <= RST_PANEL_HEIGHT;
         pc_ff      <= RST_PANEL_COUNT;
         stacked_ff <= RST_STACKED;
      end else if (csr_we) begin
         case (reg_index_type'(csr_addr))
            REG_PANEL_WIDTH:  pw_ff      <= csr_wdata[PW_W-1:0];
            REG_PANEL_HEIGHT: ph_ff      <= csr_wdata[PH_W-1:0];
            REG_PANEL_COUNT:  pc_ff      <= csr_wdata[PC_W-1:0];
            REG_STACKED_MODE: stacked_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // ---------------- item capture ----------------
   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff   <= op_type'(req_tuser);
         bcol_ff <= req_tdata[3:0];
         row_ff  <= req_tdata[8:4];
         pix_ff  <= req_tdata[16:9];
      end
   end

   // addresses beyond the store are dropped: no commands, no write
   assign addr_ok   = (32'(row_ff) < MAX_DISPLAY_HEIGHT) && (32'(bcol_ff) < ROW_BYTES);
   assign item_addr = ADDR_W'(32'(row_ff) * ROW_BYTES + 32'(bcol_ff));

   // ---------------- shared row terms ----------------
   assign disp_h = stacked_ff ? {ph_ff, 1'b0} : {1'b0, ph_ff};
   assign ly_top = ph_ff - row_ff - 5'd1;   // mirrored top half
   assign ly_bot = row_ff - ph_ff;

   always_comb begin
      ctx.op          = op_ff;
      ctx.byte_column = bcol_ff;
      ctx.panel_width = pw_ff;
      ctx.stacked     = stacked_ff;
      ctx.top_half    = stacked_ff && (row_ff < ph_ff);
      ctx.row_ok      = ({1'b0, row_ff} < disp_h);
      ctx.disp_w      = DISPW_W'(pw_ff) * DISPW_W'(pc_ff);
      if (!stacked_ff) begin
         ctx.dot_y = row_ff[DY_W-1:0];
      end else if (row_ff < ph_ff) begin
         ctx.dot_y = ly_top[DY_W-1:0];
      end else begin
         ctx.dot_y = ly_bot[DY_W-1:0];
      end
   end

   // ---------------- sequencer ----------------
   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      clr_in   = clr_ff;
      case (state_ff)
         ST_CLEAR: begin
            clr_in = clr_ff + 1'b1;
            if (clr_ff == LAST_ADDR) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            step_in = '0;
            if (accept) begin
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            step_in = step_ff + 1'b1;
            if (step_ff == LAST_STEP) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            state_in = (emit_mask != '0) ? ST_EMIT : ST_IDLE;
         end
         ST_EMIT: begin
            if (!mrg_busy) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff   <= '0;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         step_ff  <= step_in;
      end
   end

   // ---------------- frame store ----------------
   assign mem_re    = (state_ff == ST_DIV) && (step_ff == '0);
   assign mem_we    = (state_ff == ST_CLEAR) || ((state_ff == ST_FIN) && addr_ok);
   assign mem_addr  = (state_ff == ST_CLEAR) ? clr_ff : item_addr;
   assign mem_wdata = (state_ff == ST_CLEAR) ? '0 : store_byte;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_addr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_ff <= mem[mem_addr];
      end
   end

   // ---------------- lanes ----------------
   // lane i handles bit 7-i, x = byte_column*8 + i
   for (genvar i = 0; i < NUM_LANES; i++) begin : g_lane
      dmdu_lane #(
         .LANE (i)
      ) u_lane (
         .clock   (clock),
         .start   (accept),
         .step    (state_ff == ST_DIV),
         .bit_sel (STEP_W'(LAST_STEP - step_ff)),
         .ctx     (ctx),
         .old_bit (rd_ff[NUM_LANES-1-i]),
         .new_bit (pix_ff[NUM_LANES-1-i]),
         .result  (lane_res[i])
      );
      assign lane_cmd[i]                 = lane_res[i].cmd;
      assign emit_mask[i]                = lane_res[i].emit && addr_ok;
      assign store_byte[NUM_LANES-1-i]   = lane_res[i].store_bit;
   end

   // ---------------- merge ----------------
   assign mrg_load = (state_ff == ST_FIN);

   dmdu_merge u_merge (
      .clock      (clock),
      .reset      (reset),
      .load       (mrg_load),
      .load_mask  (emit_mask),
      .lane_cmd   (lane_cmd),
      .busy       (mrg_busy),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

`ifndef ASSERT_OFF
   a_clear_complete: assert property (@(posedge clock) disable iff (reset)
      ($past(state_ff == ST_CLEAR) && (state_ff == ST_IDLE)) |-> ($past(clr_ff) == LAST_ADDR))
      else $error("clearing pass left early");

   a_full_division: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FIN) |-> ($past(state_ff == ST_DIV) && ($past(step_ff) == LAST_STEP)))
      else $error("write-back before all quotient bits");

   a_merge_idle_on_load: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FIN) |-> !mrg_busy)
      else $error("new commands while previous byte still emitting");
`endif

endmodule

### sim/dmdu_flip_checker.sv
// Checker for the dot matrix difference update unit: predicts flip commands and compares them.
`timescale 1ns / 1ps

module dmdu_flip_checker #(
   parameter int MAX_DISPLAY_WIDTH  = dmdu_pkg::DEF_MAX_DISPLAY_WIDTH,
   parameter int MAX_DISPLAY_HEIGHT = dmdu_pkg::DEF_MAX_DISPLAY_HEIGHT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic [dmdu_pkg::REQ_DATA_W-1:0] req_tdata,
   input  logic                            req_tuser,
   input  logic                            req_tvalid,
   input  logic                            req_tready,
   input  logic [dmdu_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input  logic                            rsp_tlast,
   input  logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   input  logic                            csr_we,
   input  logic [dmdu_pkg::CSR_ADDR_W-1:0] csr_addr,
   input  logic [dmdu_pkg::CSR_DATA_W-1:0] csr_wdata,
   output int                              fail_count,
   output int                              flips_outstanding
);
   import dmdu_pkg::*;

   localparam int ROW_BYTES  = (MAX_DISPLAY_WIDTH + 7) / 8;
   localparam int STORE_SIZE = ROW_BYTES * MAX_DISPLAY_HEIGHT;

   typedef struct {
      cmd_type cmd;
      logic    last;
   } flip_type;

   flip_type    pending_flips[$];
   logic [7:0]  shadow_frame[STORE_SIZE];
   int unsigned geo_width, geo_height, geo_count;
   logic        geo_stacked;
   int          mismatch_total;

   assign fail_count = mismatch_total;

   initial mismatch_total = 0;

   // Flip commands caused by one byte, in left-to-right order; updates the shadow frame.
   function automatic void predict_flips(op_type op, logic [BCOL_W-1:0] bcol,
                                         logic [ROW_W-1:0] y, logic [PIX_W-1:0] pix);
      int unsigned disp_w, disp_h, addr, x, col, px, lx, ly, panel, yi, bi;
      logic [7:0]  old_bits, kept;
      logic        dot_on, emit;
      int          first_idx;
      flip_type    f;
      yi     = 32'(y);
      bi     = 32'(bcol);
      disp_w = geo_width * geo_count;
      disp_h = geo_height * (geo_stacked ? 2 : 1);
      if (yi >= MAX_DISPLAY_HEIGHT || bi >= ROW_BYTES) return;
      addr      = yi * ROW_BYTES + bi;
      old_bits  = shadow_frame[addr];
      kept      = '0;
      first_idx = pending_flips.size();
      for (int b = 0; b < 8; b++) begin
         x = bi * 8 + b;
         if (x >= disp_w || yi >= disp_h) continue;
         dot_on = (op == OP_CLEAR) ? 1'b0 : pix[7-b];
         emit   = (op == OP_CLEAR) || (old_bits[7-b] != pix[7-b]);
         kept[7-b] = dot_on;
         if (emit) begin
            col = x / geo_width;
            px  = x % geo_width;
            if (geo_stacked && yi < geo_height) begin
               // top half is mounted upside down
               panel = 2 * col + 1;
               lx    = geo_width - px - 1;
               ly    = geo_height - yi - 1;
            end else if (geo_stacked) begin
               panel = 2 * col;
               lx    = px;
               ly    = yi - geo_height;
            end else begin
               panel = col;
               lx    = px;
               ly    = yi;
            end
            f.cmd.panel_index = panel[PANEL_W-1:0];
            f.cmd.dot_x       = lx[DX_W-1:0];
            f.cmd.dot_y       = ly[DY_W-1:0];
            f.cmd.dot_state   = dot_on;
            f.last            = 1'b0;
            pending_flips.push_back(f);
         end
      end
      if (pending_flips.size() > first_idx) begin
         f = pending_flips.pop_back();
         f.last = 1'b1;
         pending_flips.push_back(f);
      end
      shadow_frame[addr] = kept;
   endfunction

   always @(posedge clock) begin
      flip_type exp_flip;
      cmd_type  got;
      if (reset) begin
         geo_width   = 32'(RST_PANEL_WIDTH);
         geo_height  = 32'(RST_PANEL_HEIGHT);
         geo_count   = 32'(RST_PANEL_COUNT);
         geo_stacked = RST_STACKED;
         for (int i = 0; i < STORE_SIZE; i++) shadow_frame[i] = '0;
         pending_flips.delete();
      end else begin
         if (csr_we) begin
            case (reg_index_type'(csr_addr))
               REG_PANEL_WIDTH:  geo_width   = 32'(csr_wdata[PW_W-1:0]);
               REG_PANEL_HEIGHT: geo_height  = 32'(csr_wdata[PH_W-1:0]);
               REG_PANEL_COUNT:  geo_count   = 32'(csr_wdata[PC_W-1:0]);
               REG_STACKED_MODE: geo_stacked = csr_wdata[0];
               default: ;
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            got = cmd_type'(rsp_tdata);
            if (pending_flips.size() == 0) begin
               $error("flip command with none expected: %h last %b", rsp_tdata, rsp_tlast);
               mismatch_total++;
            end else begin
               exp_flip = pending_flips.pop_front();
               if (got.panel_index !== exp_flip.cmd.panel_index) begin
                  $error("panel_index: expected %0d, got %0d",
                         exp_flip.cmd.panel_index, got.panel_index);
                  mismatch_total++;
               end
               if (got.dot_x !== exp_flip.cmd.dot_x) begin
                  $error("dot_x: expected %0d, got %0d", exp_flip.cmd.dot_x, got.dot_x);
                  mismatch_total++;
               end
               if (got.dot_y !== exp_flip.cmd.dot_y) begin
                  $error("dot_y: expected %0d, got %0d", exp_flip.cmd.dot_y, got.dot_y);
                  mismatch_total++;
               end
               if (got.dot_state !== exp_flip.cmd.dot_state) begin
                  $error("dot_state: expected %0d, got %0d",
                         exp_flip.cmd.dot_state, got.dot_state);
                  mismatch_total++;
               end
               if (rsp_tlast !== exp_flip.last) begin
                  $error("last: expected %0d, got %0d", exp_flip.last, rsp_tlast);
                  mismatch_total++;
               end
            end
         end
         if (req_tvalid && req_tready)
            predict_flips(op_type'(req_tuser), req_tdata[3:0], req_tdata[8:4],
                          req_tdata[16:9]);
      end
      flips_outstanding <= pending_flips.size();
   end

endmodule

### sim/testbench.sv
// Top of the simulation: clock, reset, stimulus, flow control and verdict for the update unit.
`timescale 1ns / 1ps

module testbench;
   import dmdu_pkg::*;

   localparam int CLK_PERIOD  = 10;
   localparam int RESET_TICKS = 6;
   localparam int SETTLE      = 24;        // lets a byte still in the pipe finish, with margin
   localparam int LIMIT       = 1000000;   // watchdog, far above the slowest legal run
   localparam int PHASE_BEATS = 60;

   logic                  clock = 1'b0;
   logic                  reset;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic                  req_tuser;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tlast;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic                  csr_we;
   logic [CSR_ADDR_W-1:0] csr_addr;
   logic [CSR_DATA_W-1:0] csr_wdata;

   int   fail_count;
   int   flips_outstanding;
   int   cycle_count = 0;
   int   rsp_hold = 0;
   logic stall_free = 1'b0;   // when set, neither side idles

   // Local copy of the geometry, only used to aim random beats at the display
   int unsigned cur_pw = RST_PANEL_WIDTH;
   int unsigned cur_ph = RST_PANEL_HEIGHT;
   int unsigned cur_pc = RST_PANEL_COUNT;
   logic        cur_st = RST_STACKED;

   always #(CLK_PERIOD / 2) clock = ~clock;

   dot_matrix_diff_update_unit u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   dmdu_flip_checker u_checker (
      .clock             (clock),
      .reset             (reset),
      .req_tdata         (req_tdata),
      .req_tuser         (req_tuser),
      .req_tvalid        (req_tvalid),
      .req_tready        (req_tready),
      .rsp_tdata         (rsp_tdata),
      .rsp_tlast         (rsp_tlast),
      .rsp_tvalid        (rsp_tvalid),
      .rsp_tready        (rsp_tready),
      .csr_we            (csr_we),
      .csr_addr          (csr_addr),
      .csr_wdata         (csr_wdata),
      .fail_count        (fail_count),
      .flips_outstanding (flips_outstanding)
   );

   // Idle length: mostly none or short, now and then a long one.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // Watchdog: a hung handshake ends the run here.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // Result side back-pressure. rsp_hold counts down the current stall.
   always @(posedge clock) begin
      if (rsp_hold > 0 && !stall_free) begin
         rsp_tready <= 1'b0;
         rsp_hold--;
      end else begin
         rsp_tready <= 1'b1;
         rsp_hold = 0;
         if (!stall_free && $urandom_range(0, 3) == 0) rsp_hold = pick_gap();
      end
   end

   // One input beat. tvalid stays high into the next call when no gap is drawn,
   // so back-to-back beats never drop and re-raise it in one step.
   task automatic send_byte(op_type op, logic [BCOL_W-1:0] bcol, logic [ROW_W-1:0] row,
                            logic [PIX_W-1:0] pix);
      int gap;
      gap = stall_free ? 0 : pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {7'b0, pix, row, bcol};
      do @(posedge clock); while (!req_tready);
   endtask

   // Stop sending, wait until every predicted command is back, then let a
   // zero-command byte still in the pipe finish.
   task automatic drain();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (flips_outstanding != 0);
      repeat (SETTLE) @(posedge clock);
   endtask

   // Writes all four registers, one per cycle. Only called with the unit idle.
   task automatic set_geometry(int unsigned pw, int unsigned ph, int unsigned pc, logic st);
      cur_pw = 32'(pw[PW_W-1:0]);
      cur_ph = 32'(ph[PH_W-1:0]);
      cur_pc = 32'(pc[PC_W-1:0]);
      cur_st = st;
      csr_we <= 1'b1;
      csr_addr <= REG_PANEL_WIDTH;
      csr_wdata <= pw[CSR_DATA_W-1:0];
      @(posedge clock);
      csr_addr <= REG_PANEL_HEIGHT;
      csr_wdata <= ph[CSR_DATA_W-1:0];
      @(posedge clock);
      csr_addr <= REG_PANEL_COUNT;
      csr_wdata <= pc[CSR_DATA_W-1:0];
      @(posedge clock);
      csr_addr <= REG_STACKED_MODE;
      csr_wdata <= {7'b0, st};
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   initial begin
      int unsigned      disp_w, disp_h, max_row, max_col;
      logic [BCOL_W-1:0] bcol, last_bcol;
      logic [ROW_W-1:0]  row, last_row;
      logic [PIX_W-1:0]  pix, last_pix;
      op_type            op;

      // everything known from time zero
      reset      = 1'b1;
      req_tdata  = '0;
      req_tuser  = OP_UPDATE;
      req_tvalid = 1'b0;
      rsp_tready = 1'b0;
      csr_we     = 1'b0;
      csr_addr   = REG_PANEL_WIDTH;
      csr_wdata  = '0;
      last_bcol  = '0;
      last_row   = '0;
      last_pix   = '0;

      repeat (RESET_TICKS) @(posedge clock);
      reset <= 1'b0;

      // Directed, reset geometry: 28 x 16, one panel. The first beat waits out
      // the store clearing pass.
      send_byte(OP_UPDATE, 4'd0, 5'd0, 8'hFF);    // all on
      send_byte(OP_UPDATE, 4'd0, 5'd0, 8'h00);    // all off
      send_byte(OP_UPDATE, 4'd0, 5'd0, 8'hA5);
      send_byte(OP_UPDATE, 4'd0, 5'd0, 8'hA5);    // nothing changed
      send_byte(OP_UPDATE, 4'd3, 5'd0, 8'hFF);    // straddles right edge, 4 dots inside
      send_byte(OP_UPDATE, 4'd3, 5'd0, 8'hFF);    // outside bits were stored as zero
      send_byte(OP_UPDATE, 4'd15, 5'd31, 8'hFF);  // wholly outside the display
      send_byte(OP_UPDATE, 4'd1, 5'd15, 8'hFF);   // bottom row
      send_byte(OP_UPDATE, 4'd1, 5'd16, 8'hFF);   // just below the display
      send_byte(OP_CLEAR, 4'd0, 5'd0, 8'h5A);     // pixels ignored on clear
      send_byte(OP_CLEAR, 4'd2, 5'd5, 8'hFF);     // clear of an already dark byte
      send_byte(OP_CLEAR, 4'd15, 5'd31, 8'h00);
      drain();

      // Directed, stacked 128 x 16: top half mirrored onto odd panels
      set_geometry(128, 16, 1, 1'b1);
      send_byte(OP_UPDATE, 4'd15, 5'd31, 8'hFF);
      send_byte(OP_UPDATE, 4'd0, 5'd0, 8'h81);
      send_byte(OP_UPDATE, 4'd7, 5'd15, 8'h55);
      send_byte(OP_UPDATE, 4'd7, 5'd16, 8'hAA);
      send_byte(OP_CLEAR, 4'd15, 5'd31, 8'h00);
      drain();

      // Empty display: zero registers, nothing is issued, store goes dark
      set_geometry(0, 0, 0, 1'b0);
      send_byte(OP_UPDATE, 4'd0, 5'd1, 8'hFF);
      send_byte(OP_CLEAR, 4'd0, 5'd0, 8'hFF);
      drain();

      // Overwide registers: panel index and local coordinates wrap
      set_geometry(1, 31, 15, 1'b1);
      send_byte(OP_UPDATE, 4'd1, 5'd0, 8'hFF);    // panels 2c+1 past 15
      send_byte(OP_UPDATE, 4'd0, 5'd30, 8'hFF);
      drain();
      set_geometry(255, 31, 15, 1'b1);
      send_byte(OP_UPDATE, 4'd15, 5'd2, 8'hFF);   // mirrored x wraps
      send_byte(OP_CLEAR, 4'd15, 5'd31, 8'h00);
      drain();

      // Random phases, mostly aimed inside the display.
      for (int ph = 0; ph < 8; ph++) begin
         case (ph)
            0: set_geometry(RST_PANEL_WIDTH, RST_PANEL_HEIGHT, RST_PANEL_COUNT, RST_STACKED);
            1: set_geometry(1, 1, 1, 1'b0);
            2: set_geometry(128, 16, 8, 1'b1);
            3: set_geometry(8, 8, 8, 1'b1);
            4: set_geometry(1, 16, 8, 1'b0);
            7: set_geometry(255, 31, 15, 1'b1);
            default: set_geometry($urandom_range(1, 128), $urandom_range(1, 16),
                                  $urandom_range(1, 8), 1'($urandom_range(0, 1)));
         endcase
         stall_free = (ph == 2 || ph == 5);
         disp_w  = cur_pw * cur_pc;
         disp_h  = cur_ph * (cur_st ? 2 : 1);
         max_row = (disp_h > 32) ? 32 : disp_h;
         max_col = ((disp_w + 7) / 8 > 16) ? 16 : (disp_w + 7) / 8;
         for (int i = 0; i < PHASE_BEATS; i++) begin
            // once per phase the sender holds off until all commands are back
            if (i == PHASE_BEATS / 2) drain();
            op = ($urandom_range(0, 7) == 0) ? OP_CLEAR : OP_UPDATE;
            if ($urandom_range(0, 9) == 0) begin
               // same byte again: usually nothing to flip
               bcol = last_bcol;
               row  = last_row;
               pix  = last_pix;
            end else begin
               if ($urandom_range(0, 9) != 0 && max_row > 0 && max_col > 0) begin
                  row  = ROW_W'($urandom_range(0, max_row - 1));
                  bcol = BCOL_W'($urandom_range(0, max_col - 1));
               end else begin
                  row  = ROW_W'($urandom);
                  bcol = BCOL_W'($urandom);
               end
               pix = PIX_W'($urandom);
            end
            send_byte(op, bcol, row, pix);
            last_bcol = bcol;
            last_row  = row;
            last_pix  = pix;
         end
         drain();
      end

      if (fail_count == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
